// File: rtl/sha1_hash_engine_defines.svh
// Assertion macros shared by the verification files of the SHA-1 engine.
// Has no dependencies; it is included by the checker module.
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sha1 engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHA1_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha1 engine: next-cycle check failed");

`endif

// File: rtl/sha1_pkg.sv
// Types, constants and helper functions of the SHA-1 engine.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package sha1_pkg;

	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned ROUNDS       = 80;

	localparam logic [31:0] K_CH   = 32'h5a827999;
	localparam logic [31:0] K_PAR1 = 32'h6ed9eba1;
	localparam logic [31:0] K_MAJ  = 32'h8f1bbcdc;
	localparam logic [31:0] K_PAR2 = 32'hca62c1d6;
	localparam logic [7:0]  PAD_MARK = 8'h80;

	localparam logic [5:0] FILL_LAST      = 6'd63;
	localparam logic [5:0] FILL_LEN_START = 6'd56;
	localparam logic [6:0] ROUND_LAST     = 7'(ROUNDS - 1);
	localparam logic [2:0] INDEX_LAST     = 3'(DIGEST_WORDS - 1);

	localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	typedef enum logic [1:0] {
		SEL_INPUT = 2'd0,
		SEL_MARK  = 2'd1,
		SEL_ZERO  = 2'd2,
		SEL_LEN   = 2'd3
	} byte_sel_t;

	typedef enum logic [1:0] {
		GRP_CH   = 2'd0,
		GRP_PAR1 = 2'd1,
		GRP_MAJ  = 2'd2,
		GRP_PAR2 = 2'd3
	} round_grp_t;

	typedef struct packed {
		logic       load_byte;
		byte_sel_t  byte_sel;
		logic       add_len;
		logic       round_en;
		round_grp_t round_grp;
		logic       chain_add;
		logic       chain_init;
		logic [2:0] rd_index;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} dp_status_t;

	function automatic logic [31:0] round_k(input round_grp_t grp);
		logic [31:0] k;
		unique case (grp)
			GRP_CH:   k = K_CH;
			GRP_PAR1: k = K_PAR1;
			GRP_MAJ:  k = K_MAJ;
			GRP_PAR2: k = K_PAR2;
			default:  k = K_CH;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// File: rtl/sha1_stream_if.sv
// Valid/ready channel interfaces for message bytes and digest words.
// No dependencies; used by the top level.
`default_nettype none

interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, output data_byte, output byte_present,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input byte_present,
		input end_of_message, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

`default_nettype wire

// File: rtl/sha1_ctrl.sv
// Sequencer of the SHA-1 engine: byte intake, padding, rounds and digest output.
// Depends on sha1_pkg; drives sha1_datapath through command and status structs.
`default_nettype none

module sha1_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 byte_present,
	input  logic                 end_of_message,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           word_index,
	output logic                 last_word,
	output sha1_pkg::dp_cmd_t    cmd,
	input  sha1_pkg::dp_status_t status
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t     state_q;
	logic [6:0] rnd_q;
	logic [2:0] idx_q;
	logic       pad_q;
	logic       mark_q;
	logic       lenph_q;
	logic       done_q;

	logic                block_full;
	sha1_pkg::byte_sel_t pad_sel;
	sha1_pkg::round_grp_t grp;

	assign block_full = (status.fill == sha1_pkg::FILL_LAST);

	// The mark goes first; the length starts at byte 56 of the last block.
	always_comb begin
		if (!mark_q) begin
			pad_sel = sha1_pkg::SEL_MARK;
		end else if (lenph_q || status.fill == sha1_pkg::FILL_LEN_START) begin
			pad_sel = sha1_pkg::SEL_LEN;
		end else begin
			pad_sel = sha1_pkg::SEL_ZERO;
		end
	end

	always_comb begin
		if (rnd_q < 7'd20) begin
			grp = sha1_pkg::GRP_CH;
		end else if (rnd_q < 7'd40) begin
			grp = sha1_pkg::GRP_PAR1;
		end else if (rnd_q < 7'd60) begin
			grp = sha1_pkg::GRP_MAJ;
		end else begin
			grp = sha1_pkg::GRP_PAR2;
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.byte_sel   = sha1_pkg::SEL_INPUT;
		cmd.round_grp  = grp;
		cmd.rd_index   = idx_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_byte = in_valid && byte_present;
				cmd.add_len   = in_valid && byte_present;
			end
			ST_PAD: begin
				cmd.load_byte = 1'b1;
				cmd.byte_sel  = pad_sel;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
			end
			ST_FINAL: begin
				cmd.chain_add = 1'b1;
			end
			ST_EMIT: begin
				out_valid      = 1'b1;
				cmd.chain_init = out_ready && (idx_q == sha1_pkg::INDEX_LAST);
			end
			default: begin
			end
		endcase
	end

	assign word_index = idx_q;
	assign last_word  = (idx_q == sha1_pkg::INDEX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenph_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pad_q   <= end_of_message;
						mark_q  <= 1'b0;
						lenph_q <= 1'b0;
						done_q  <= 1'b0;
						if (byte_present && block_full) begin
							state_q <= ST_ROUND;
						end else if (end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (pad_sel == sha1_pkg::SEL_LEN) begin
						lenph_q <= 1'b1;
					end
					if (block_full) begin
						state_q <= ST_ROUND;
						// A block that closes on a length byte is the final one.
						if (pad_sel == sha1_pkg::SEL_LEN) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_ROUND: begin
					if (rnd_q == sha1_pkg::ROUND_LAST) begin
						rnd_q   <= '0;
						state_q <= ST_FINAL;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				ST_FINAL: begin
					idx_q <= '0;
					if (done_q) begin
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						if (idx_q == sha1_pkg::INDEX_LAST) begin
							state_q <= ST_IDLE;
							pad_q   <= 1'b0;
							done_q  <= 1'b0;
							idx_q   <= '0;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha1_datapath.sv
// SHA-1 datapath: byte packing, schedule window, round unit, chain and length.
// Depends on sha1_pkg; commanded by sha1_ctrl.
`default_nettype none

module sha1_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha1_pkg::dp_cmd_t    cmd,
	output sha1_pkg::dp_status_t status,
	input  logic [7:0]           data_byte,
	output logic [31:0]          digest_word
);

	logic [31:0] chain_q [sha1_pkg::DIGEST_WORDS];
	logic [31:0] w_q [16];
	logic [23:0] acc_q;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;

	logic [7:0]  len_byte;
	logic [7:0]  byte_in;
	logic        word_done;
	logic        block_done;
	logic [31:0] w_next;
	logic [31:0] f;
	logic [31:0] t_sum;

	assign status.fill = fill_q;
	assign digest_word = chain_q[cmd.rd_index];

	// Length bytes go out most significant first, starting at byte 56.
	assign len_byte = 8'(len_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		case (cmd.byte_sel)
			sha1_pkg::SEL_INPUT: byte_in = data_byte;
			sha1_pkg::SEL_MARK:  byte_in = sha1_pkg::PAD_MARK;
			sha1_pkg::SEL_ZERO:  byte_in = 8'h00;
			default:             byte_in = len_byte;
		endcase
	end

	assign word_done  = cmd.load_byte && (fill_q[1:0] == 2'b11);
	assign block_done = cmd.load_byte && (fill_q == sha1_pkg::FILL_LAST);

	// Window holds W[t] .. W[t+15]; the next schedule word enters at the top.
	always_comb begin
		w_next = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_next = {w_next[30:0], w_next[31]};
	end

	always_comb begin
		case (cmd.round_grp)
			sha1_pkg::GRP_CH:  f = (b_q & c_q) | (~b_q & d_q);
			sha1_pkg::GRP_MAJ: f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			default:           f = b_q ^ c_q ^ d_q;
		endcase
		t_sum = {a_q[26:0], a_q[31:27]} + f + e_q + sha1_pkg::round_k(cmd.round_grp)
			+ w_q[0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			acc_q <= {acc_q[15:0], byte_in};
		end
		if (word_done) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= {acc_q, byte_in};
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_next;
		end
		if (block_done) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha1_pkg::H_INIT;
			len_q   <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.chain_init) begin
				chain_q <= sha1_pkg::H_INIT;
				len_q   <= '0;
				fill_q  <= '0;
			end else begin
				if (cmd.chain_add) begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
				end
				if (cmd.add_len) begin
					len_q <= len_q + 64'd8;
				end
				if (cmd.load_byte) begin
					fill_q <= fill_q + 6'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/sha1_hash_engine.sv
// Top level of the SHA-1 engine: joins the sequencer and the datapath.
// Depends on sha1_pkg, sha1_stream_if, sha1_ctrl and sha1_datapath.
//
// Channel  Dir  Beat payload
// msg      in   data_byte[7:0], byte_present, end_of_message
// digest   out  digest_word[31:0], word_index[2:0], last_word
//
// A beat that fills a 64-byte block starts its compression: 80 rounds on a
// single round unit, then a step that folds the result into the chain. At
// end of message the padding bytes go in at one per cycle, pausing while
// each closed block is compressed, and the five digest beats follow.
// msg.ready is low from a full block until the compression ends, and from
// end of message until the last digest beat.
// Reset is asynchronous and loads the initial chain; no clearing pass.
`default_nettype none

module sha1_hash_engine (
	input  logic              clk,
	input  logic              arst_n,
	sha1_in_if.sink           msg,
	sha1_out_if.source        digest
);

	sha1_pkg::dp_cmd_t    cmd;
	sha1_pkg::dp_status_t status;

	sha1_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (msg.valid),
		.in_ready       (msg.ready),
		.byte_present   (msg.byte_present),
		.end_of_message (msg.end_of_message),
		.out_valid      (digest.valid),
		.out_ready      (digest.ready),
		.word_index     (digest.word_index),
		.last_word      (digest.last_word),
		.cmd            (cmd),
		.status         (status)
	);

	sha1_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.data_byte   (msg.data_byte),
		.digest_word (digest.digest_word)
	);

endmodule

`default_nettype wire

// File: rtl/sha1_hash_engine_checker.sv
// Port-level checks of the SHA-1 engine, bound to the top level.
// Depends on sha1_hash_engine_defines.svh and the top level's channel ports.
`default_nettype none
`include "sha1_hash_engine_defines.svh"

module sha1_hash_engine_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// A stalled digest beat holds its contents.
	`SHA1_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(digest_word) && $stable(word_index))

	// Digest beats and message intake never overlap.
	`SHA1_ASSERT_IMPLY(a_no_intake, clk, arst_n, out_valid, !in_ready)

	// Only the fifth word carries the last flag.
	`SHA1_ASSERT_IMPLY(a_last_flag, clk, arst_n, out_valid, last_word == (word_index == 3'd4))

	// Words come out back to back in order until the last one.
	`SHA1_ASSERT_NEXT(a_word_order, clk, arst_n, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)

endmodule

bind sha1_hash_engine sha1_hash_engine_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (msg.ready),
	.out_valid   (digest.valid),
	.out_ready   (digest.ready),
	.digest_word (digest.digest_word),
	.word_index  (digest.word_index),
	.last_word   (digest.last_word)
);

`default_nettype wire
